// ===== rtl/byte_ring_buffer_burst_fifo_macros.svh =====
`ifndef BYTE_RING_BUFFER_BURST_FIFO_MACROS_SVH
`define BYTE_RING_BUFFER_BURST_FIFO_MACROS_SVH

// same-cycle implication, disabled in reset
`define BRB_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("brb check failed");

// next-cycle implication, disabled in reset
`define BRB_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("brb check failed");

`endif

// ===== rtl/brb_pkg.sv =====
package brb_pkg;

	localparam int CAP_W  = 11;
	localparam int CNT_W  = 10;
	localparam int BYTE_W = 8;
	localparam int PTR_W  = 16;
	localparam int NUM_W  = 7;
	localparam int Q_DEPTH = 4;
	localparam int Q_AW    = 2;

	localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

	typedef enum logic [1:0] {
		KIND_WR_REQ  = 2'd0,
		KIND_WR_DATA = 2'd1,
		KIND_RD_REQ  = 2'd2,
		KIND_CLEAR   = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_WR_OK    = 3'd0,
		ST_WR_REJ   = 3'd1,
		ST_RD_BYTE  = 3'd2,
		ST_RD_EMPTY = 3'd3,
		ST_CLEARED  = 3'd4
	} status_t;

	typedef struct packed {
		status_t           status;
		logic [PTR_W-1:0]  ptr;
		logic [NUM_W-1:0]  num;
		logic [CNT_W-1:0]  amount;
		logic [CNT_W-1:0]  fill;
		logic [CNT_W-1:0]  free;
	} job_t;

	typedef struct packed {
		logic              we;
		logic [PTR_W-1:0]  addr;
		logic [BYTE_W-1:0] data;
	} ram_wr_t;

	typedef struct packed {
		logic              re;
		logic [PTR_W-1:0]  addr;
	} ram_rd_t;

endpackage

// ===== rtl/brb_ifs.sv =====
interface brb_cfg_if;
	import brb_pkg::*;
	logic             valid;
	logic             ready;
	logic [CAP_W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface brb_req_if;
	import brb_pkg::*;
	logic              valid;
	logic              ready;
	logic [1:0]        kind;
	logic [CNT_W-1:0]  count;
	logic [BYTE_W-1:0] data_byte;
	modport source (output valid, output kind, output count, output data_byte, input ready);
	modport sink (input valid, input kind, input count, input data_byte, output ready);
endinterface

interface brb_rsp_if;
	import brb_pkg::*;
	logic              valid;
	logic              ready;
	logic [2:0]        status;
	logic [BYTE_W-1:0] read_byte;
	logic              last;
	logic [CNT_W-1:0]  amount;
	logic [CNT_W-1:0]  fill_level;
	logic [CNT_W-1:0]  free_space;
	modport source (output valid, output status, output read_byte, output last,
		output amount, output fill_level, output free_space, input ready);
	modport sink (input valid, input status, input read_byte, input last,
		input amount, input fill_level, input free_space, output ready);
endinterface

// ===== rtl/byte_ring_buffer_burst_fifo.sv =====
// Circular byte FIFO over a DEPTH-byte RAM, ring size set by the capacity register
// (clamped to 2..DEPTH, one slot kept empty). The front takes one beat a cycle while ready:
// write and read requests and clears are decided at once and queued (four entries)
// for the back, and a write data byte goes straight into the RAM in its cycle. The
// back sends one result beat a cycle within a job while the response port is not stalled;
// a read request yields up to MAX_READ byte beats, one per cycle from the single RAM read
// port. A job passes the queue, the back's job register, stage s1 and the output register.
// A data byte waits while an earlier read run is still being fetched from the RAM.
// The RAM needs no clearing pass after reset. Capacity writes empty the ring.
module byte_ring_buffer_burst_fifo #(
	parameter int DEPTH = 1024,
	parameter int MAX_READ = 64,
	localparam int AW = $clog2(DEPTH),
	localparam int CW = (AW + 1 < brb_pkg::CAP_W) ? AW + 1 : brb_pkg::CAP_W
) (
	input  logic      clk,
	input  logic      arst_n,
	brb_cfg_if.sink   cfg,
	brb_req_if.sink   req,
	brb_rsp_if.source rsp
);
	import brb_pkg::*;

	logic              push;
	job_t              push_job;
	logic              q_full;
	logic              pop;
	logic              q_valid;
	job_t              pop_job;
	logic              rd_done;
	ram_wr_t           wr;
	ram_rd_t           rd;
	logic [BYTE_W-1:0] rdata;
	logic [CW-1:0]     cap;

	brb_front #(.DEPTH(DEPTH), .MAX_READ(MAX_READ)) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.req     (req),
		.push    (push),
		.job     (push_job),
		.q_full  (q_full),
		.rd_done (rd_done),
		.wr      (wr),
		.cap     (cap)
	);

	brb_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_job  (push_job),
		.full      (q_full),
		.pop       (pop),
		.not_empty (q_valid),
		.pop_job   (pop_job)
	);

	brb_ram #(.DEPTH(DEPTH)) u_ram (
		.clk   (clk),
		.wr    (wr),
		.rd    (rd),
		.rdata (rdata)
	);

	brb_back #(.DEPTH(DEPTH)) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cap     (cap),
		.q_valid (q_valid),
		.q_job   (pop_job),
		.pop     (pop),
		.rd      (rd),
		.rdata   (rdata),
		.rd_done (rd_done),
		.rsp     (rsp)
	);

endmodule

// ===== rtl/brb_ram.sv =====
module brb_ram #(
	parameter int DEPTH = 1024,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic                      clk,
	input  brb_pkg::ram_wr_t          wr,
	input  brb_pkg::ram_rd_t          rd,
	output logic [brb_pkg::BYTE_W-1:0] rdata
);
	import brb_pkg::*;

	logic [BYTE_W-1:0] mem [DEPTH];
	logic [BYTE_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem[wr.addr[AW-1:0]] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd.re) begin
			rdata_q <= mem[rd.addr[AW-1:0]];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/brb_queue.sv =====
module brb_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  brb_pkg::job_t push_job,
	output logic          full,
	input  logic          pop,
	output logic          not_empty,
	output brb_pkg::job_t pop_job
);
	import brb_pkg::*;

	job_t            slot_q [Q_DEPTH];
	logic [Q_AW-1:0] wr_q;
	logic [Q_AW-1:0] rd_q;
	logic [Q_AW:0]   cnt_q;

	assign full      = (cnt_q == (Q_AW+1)'(Q_DEPTH));
	assign not_empty = (cnt_q != '0);
	assign pop_job   = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== rtl/brb_front.sv =====
module brb_front #(
	parameter int DEPTH = 1024,
	parameter int MAX_READ = 64,
	localparam int AW = $clog2(DEPTH),
	localparam int CW = (AW + 1 < brb_pkg::CAP_W) ? AW + 1 : brb_pkg::CAP_W
) (
	input  logic             clk,
	input  logic             arst_n,
	brb_cfg_if.sink          cfg,
	brb_req_if.sink          req,
	output logic             push,
	output brb_pkg::job_t    job,
	input  logic             q_full,
	input  logic             rd_done,
	output brb_pkg::ram_wr_t wr,
	output logic [CW-1:0]    cap
);
	import brb_pkg::*;

	logic [CAP_W-1:0] capacity_q;
	logic [AW-1:0]    rp_q;
	logic [AW-1:0]    wp_q;
	logic [CNT_W-1:0] rem_q;
	logic [CW-1:0]    fill_q;
	logic [2:0]       pend_q;

	logic [CW-1:0]    free_w;
	logic             acc;
	logic [11:0]      min_w;
	logic [NUM_W-1:0] n_w;
	logic [CW-1:0]    fill_rd;
	logic [AW+1:0]    rp_sum;
	logic [AW-1:0]    rp_rd;
	logic [AW:0]      wp_inc;
	logic             wr_ok;

	always_comb begin
		if (capacity_q < CAP_W'(2)) begin
			cap = CW'(2);
		end else if (32'(capacity_q) > 32'(DEPTH)) begin
			cap = CW'(DEPTH);
		end else begin
			cap = CW'(capacity_q);
		end
	end

	assign free_w    = cap - fill_q - 1'b1;
	assign cfg.ready = 1'b1;

	always_comb begin
		if (kind_t'(req.kind) == KIND_WR_DATA) begin
			req.ready = (pend_q == '0);
		end else begin
			req.ready = !q_full;
		end
	end

	assign acc = req.valid && req.ready;

	// read run length and pointer after it
	always_comb begin
		min_w = (12'(req.count) < 12'(fill_q)) ? 12'(req.count) : 12'(fill_q);
		n_w   = (min_w > 12'(MAX_READ)) ? NUM_W'(MAX_READ) : NUM_W'(min_w);
		fill_rd = fill_q - CW'(n_w);
		rp_sum  = (AW+2)'(rp_q) + (AW+2)'(n_w);
		if (rp_sum >= (AW+2)'(cap)) begin
			rp_rd = AW'(rp_sum - (AW+2)'(cap));
		end else begin
			rp_rd = AW'(rp_sum);
		end
	end

	assign wp_inc = (AW+1)'(wp_q) + 1'b1;
	assign wr_ok  = (rem_q != '0) && ((fill_q + 1'b1) < cap);

	always_comb begin
		push       = 1'b0;
		job        = '0;
		job.ptr    = PTR_W'(rp_q);
		wr.we      = 1'b0;
		wr.addr    = PTR_W'(wp_q);
		wr.data    = req.data_byte;
		if (acc) begin
			case (kind_t'(req.kind))
				KIND_WR_REQ: begin
					push     = 1'b1;
					job.fill = CNT_W'(fill_q);
					job.free = CNT_W'(free_w);
					if (12'(req.count) > 12'(free_w)) begin
						job.status = ST_WR_REJ;
					end else begin
						job.status = ST_WR_OK;
						job.amount = req.count;
					end
				end
				KIND_WR_DATA: begin
					wr.we = wr_ok;
				end
				KIND_RD_REQ: begin
					push     = 1'b1;
					job.fill = CNT_W'(fill_rd);
					job.free = CNT_W'(cap - fill_rd - 1'b1);
					if (n_w == '0) begin
						job.status = ST_RD_EMPTY;
					end else begin
						job.status = ST_RD_BYTE;
						job.num    = n_w;
						job.amount = CNT_W'(n_w);
					end
				end
				default: begin
					push       = 1'b1;
					job.status = ST_CLEARED;
					job.free   = CNT_W'(cap - 1'b1);
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
			rp_q       <= '0;
			wp_q       <= '0;
			rem_q      <= '0;
			fill_q     <= '0;
			pend_q     <= '0;
		end else begin
			case ({push && (job.status == ST_RD_BYTE), rd_done})
				2'b10:   pend_q <= pend_q + 1'b1;
				2'b01:   pend_q <= pend_q - 1'b1;
				default: pend_q <= pend_q;
			endcase
			if (cfg.valid) begin
				capacity_q <= cfg.data;
				rp_q       <= '0;
				wp_q       <= '0;
				rem_q      <= '0;
				fill_q     <= '0;
			end else if (acc) begin
				case (kind_t'(req.kind))
					KIND_WR_REQ: begin
						rem_q <= (12'(req.count) > 12'(free_w)) ? '0 : req.count;
					end
					KIND_WR_DATA: begin
						if (wr_ok) begin
							wp_q   <= (wp_inc >= (AW+1)'(cap)) ? '0 : AW'(wp_inc);
							rem_q  <= rem_q - 1'b1;
							fill_q <= fill_q + 1'b1;
						end
					end
					KIND_RD_REQ: begin
						rp_q   <= rp_rd;
						fill_q <= fill_rd;
					end
					default: begin
						rp_q   <= '0;
						wp_q   <= '0;
						rem_q  <= '0;
						fill_q <= '0;
					end
				endcase
			end
		end
	end

endmodule

// ===== rtl/brb_back.sv =====
module brb_back #(
	parameter int DEPTH = 1024,
	localparam int AW = $clog2(DEPTH),
	localparam int CW = (AW + 1 < brb_pkg::CAP_W) ? AW + 1 : brb_pkg::CAP_W
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [CW-1:0]              cap,
	input  logic                       q_valid,
	input  brb_pkg::job_t              q_job,
	output logic                       pop,
	output brb_pkg::ram_rd_t           rd,
	input  logic [brb_pkg::BYTE_W-1:0] rdata,
	output logic                       rd_done,
	brb_rsp_if.source                  rsp
);
	import brb_pkg::*;

	logic             busy_q;
	job_t             job_q;
	logic [AW-1:0]    ptr_q;
	logic [NUM_W-1:0] left_q;

	logic             s1_q;
	status_t          status_s1;
	logic             last_s1;
	logic [CNT_W-1:0] amount_s1;
	logic [CNT_W-1:0] fill_s1;
	logic [CNT_W-1:0] free_s1;

	logic              out_valid_q;
	logic [2:0]        status_q;
	logic [BYTE_W-1:0] byte_q;
	logic              last_q;
	logic [CNT_W-1:0]  amount_q;
	logic [CNT_W-1:0]  fill_q;
	logic [CNT_W-1:0]  free_q;

	logic          out_free;
	logic          s1_adv;
	logic          issue;
	logic          is_rd;
	logic [AW:0]   ptr_inc;

	assign out_free = !out_valid_q || rsp.ready;
	assign s1_adv   = s1_q && out_free;
	assign issue    = busy_q && (!s1_q || s1_adv);
	assign pop      = !busy_q && q_valid;
	assign is_rd    = (job_q.status == ST_RD_BYTE);
	assign rd.re    = issue && is_rd;
	assign rd.addr  = PTR_W'(ptr_q);
	assign rd_done  = issue && is_rd && (left_q == NUM_W'(1));
	assign ptr_inc  = (AW+1)'(ptr_q) + 1'b1;

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= q_job;
		end
		if (issue) begin
			status_s1 <= job_q.status;
			last_s1   <= (left_q == NUM_W'(1));
			amount_s1 <= job_q.amount;
			fill_s1   <= job_q.fill;
			free_s1   <= job_q.free;
		end
		if (s1_adv) begin
			status_q <= status_s1;
			byte_q   <= (status_s1 == ST_RD_BYTE) ? rdata : '0;
			last_q   <= last_s1;
			amount_q <= amount_s1;
			fill_q   <= fill_s1;
			free_q   <= free_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			ptr_q       <= '0;
			left_q      <= '0;
			s1_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
				ptr_q  <= q_job.ptr[AW-1:0];
				left_q <= (q_job.status == ST_RD_BYTE) ? q_job.num : NUM_W'(1);
			end else if (issue) begin
				left_q <= left_q - 1'b1;
				ptr_q  <= (ptr_inc >= (AW+1)'(cap)) ? '0 : AW'(ptr_inc);
				if (left_q == NUM_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
			if (issue) begin
				s1_q <= 1'b1;
			end else if (s1_adv) begin
				s1_q <= 1'b0;
			end
			if (s1_adv) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.status     = status_q;
	assign rsp.read_byte  = byte_q;
	assign rsp.last       = last_q;
	assign rsp.amount     = amount_q;
	assign rsp.fill_level = fill_q;
	assign rsp.free_space = free_q;

endmodule

// ===== rtl/brb_checker.sv =====
`include "byte_ring_buffer_burst_fifo_macros.svh"

module brb_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       valid,
	input logic                       ready,
	input logic [2:0]                 status,
	input logic [brb_pkg::BYTE_W-1:0] read_byte,
	input logic                       last,
	input logic [brb_pkg::CNT_W-1:0]  amount,
	input logic [brb_pkg::CNT_W-1:0]  fill_level,
	input logic [brb_pkg::CNT_W-1:0]  free_space
);
	import brb_pkg::*;

	// stalled beat holds
	`BRB_ASSERT_NXT(a_hold, valid && !ready, valid && $stable({status, read_byte, last, amount, fill_level, free_space}))

	// only read runs span several beats
	`BRB_ASSERT_IMP(a_single, valid && (status != ST_RD_BYTE), last)

	// no data outside a read byte beat
	`BRB_ASSERT_IMP(a_nobyte, valid && (status != ST_RD_BYTE), read_byte == '0)

	// empty read and clear report nothing moved
	`BRB_ASSERT_IMP(a_empty, valid && ((status == ST_RD_EMPTY) || (status == ST_CLEARED)), amount == '0)

endmodule

bind byte_ring_buffer_burst_fifo brb_checker u_brb_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.valid      (rsp.valid),
	.ready      (rsp.ready),
	.status     (rsp.status),
	.read_byte  (rsp.read_byte),
	.last       (rsp.last),
	.amount     (rsp.amount),
	.fill_level (rsp.fill_level),
	.free_space (rsp.free_space)
);
